/* hw/rtl/qss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package qss_pkg;

    localparam int NUM_SLOTS   = 128;
    localparam int SLOT_BYTES  = 64;
    localparam int SLOT_W      = 7;
    localparam int POS_W       = 6;
    localparam int CNT_W       = 8;
    localparam int MAX_RES     = 5;
    localparam int RES_IDX_W   = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef enum logic [1:0] {
        KIND_STORE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_PCT  = 2'd1,
        ESC_PCT2 = 2'd2
    } t_esc;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        t_kind             out_kind;
        logic [SLOT_W-1:0] slot_index;
        logic [POS_W-1:0]  char_position;
        logic [7:0]        stored_char;
        logic [CNT_W-1:0]  arg_count;
        logic              last_result;
    } t_out;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        logic [7:0]        ch;
        logic [CNT_W-1:0]  cnt;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0]   res;
        logic [RES_IDX_W-1:0] cnt;
    } t_bundle;

    function automatic t_res mk_res(t_kind k, logic [SLOT_W-1:0] s, logic [POS_W-1:0] p,
                                    logic [7:0] ch, logic [CNT_W-1:0] cnt);
        t_res r;
        r.kind = k;
        r.slot = s;
        r.pos  = p;
        r.ch   = ch;
        r.cnt  = cnt;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/qss_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module qss_front import qss_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_in     i_data,
    output      logic    o_ready,
    output      logic    o_push,
    output      t_bundle o_bundle,
    input  wire logic    i_full
);

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_vpend, n_vpend;
    logic              r_plain, n_plain;
    t_esc              r_esc, n_esc;
    logic              r_seen, n_seen;

    logic              w_acc;
    logic              w_end;
    t_bundle           v_b;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && o_ready;
    assign w_end   = i_data.end_of_string || (i_data.in_byte == CH_NUL);

    always_comb begin
        logic [7:0]        c;
        logic              flush_pct;
        logic              flush_two;
        logic              do_space;
        logic              do_handle;
        logic [SLOT_W:0]   v_next;
        c         = i_data.in_byte;
        n_slot    = r_slot;
        n_pos     = r_pos;
        n_vpend   = r_vpend;
        n_plain   = r_plain;
        n_esc     = r_esc;
        n_seen    = r_seen;
        v_b       = '0;
        flush_pct = 1'b0;
        flush_two = 1'b0;
        do_space  = 1'b0;
        do_handle = 1'b0;
        v_next    = '0;
        if (w_end) begin
            if (!r_seen) begin
                v_b.res[v_b.cnt] = mk_res(KIND_ERROR, '0, '0, CH_NUL, '0);
                v_b.cnt = v_b.cnt + 1'b1;
            end else begin
                flush_pct = (r_esc != ESC_NONE);
                flush_two = (r_esc == ESC_PCT2);
            end
        end else begin
            n_seen = 1'b1;
            case (r_esc)
                ESC_PCT: begin
                    if (c == CH_TWO) begin
                        n_esc = ESC_PCT2;
                    end else begin
                        n_esc     = ESC_NONE;
                        flush_pct = 1'b1;
                        do_handle = 1'b1;
                    end
                end
                ESC_PCT2: begin
                    n_esc = ESC_NONE;
                    if (c == CH_ZERO) begin
                        do_space = 1'b1;
                    end else begin
                        flush_pct = 1'b1;
                        flush_two = 1'b1;
                        do_handle = 1'b1;
                    end
                end
                default: do_handle = 1'b1;
            endcase
        end

        // held escape bytes, then the space or the new byte
        if (flush_pct) begin
            if (n_pos < POS_W'(SLOT_BYTES - 1)) begin
                v_b.res[v_b.cnt] = mk_res(KIND_STORE, n_slot, n_pos, CH_PCT, '0);
                v_b.cnt = v_b.cnt + 1'b1;
                n_pos = n_pos + 1'b1;
            end
            n_plain = 1'b1;
        end
        if (flush_two) begin
            if (n_pos < POS_W'(SLOT_BYTES - 1)) begin
                v_b.res[v_b.cnt] = mk_res(KIND_STORE, n_slot, n_pos, CH_TWO, '0);
                v_b.cnt = v_b.cnt + 1'b1;
                n_pos = n_pos + 1'b1;
            end
            n_plain = 1'b1;
        end
        if (do_space) begin
            if (n_pos < POS_W'(SLOT_BYTES - 1)) begin
                v_b.res[v_b.cnt] = mk_res(KIND_STORE, n_slot, n_pos, CH_SPACE, '0);
                v_b.cnt = v_b.cnt + 1'b1;
                n_pos = n_pos + 1'b1;
            end
            n_plain = 1'b0;
        end
        if (do_handle) begin
            if (c == CH_PCT) begin
                n_esc = ESC_PCT;
            end else if (((c == CH_AMP) || (c == CH_EQ)) && n_plain) begin
                v_b.res[v_b.cnt] = mk_res(KIND_STORE, n_slot, n_pos, CH_NUL, '0);
                v_b.cnt = v_b.cnt + 1'b1;
                if (c == CH_EQ) begin
                    v_next  = n_vpend ? {1'b0, n_slot} : {1'b0, n_slot} + 1'b1;
                    n_vpend = 1'b1;
                end else begin
                    if (!n_vpend) begin
                        // name without value skips one empty slot
                        if ({1'b0, n_slot} + 1'b1 < (SLOT_W+1)'(NUM_SLOTS)) begin
                            v_b.res[v_b.cnt] = mk_res(KIND_STORE, n_slot + 1'b1, '0,
                                                      CH_NUL, '0);
                            v_b.cnt = v_b.cnt + 1'b1;
                        end
                        v_next = {1'b0, n_slot} + (SLOT_W+1)'(2);
                    end else begin
                        v_next = {1'b0, n_slot} + 1'b1;
                    end
                    n_vpend = 1'b0;
                end
                if (v_next >= (SLOT_W+1)'(NUM_SLOTS)) begin
                    v_next = (SLOT_W+1)'(NUM_SLOTS - 1);
                end
                n_slot  = v_next[SLOT_W-1:0];
                n_pos   = '0;
                n_plain = 1'b0;
            end else begin
                if (n_pos < POS_W'(SLOT_BYTES - 1)) begin
                    v_b.res[v_b.cnt] = mk_res(KIND_STORE, n_slot, n_pos, c, '0);
                    v_b.cnt = v_b.cnt + 1'b1;
                    n_pos = n_pos + 1'b1;
                end
                n_plain = 1'b1;
            end
        end

        if (w_end) begin
            if (r_seen) begin
                v_b.res[v_b.cnt] = mk_res(KIND_STORE, n_slot, n_pos, CH_NUL, '0);
                v_b.cnt = v_b.cnt + 1'b1;
                v_b.res[v_b.cnt] = mk_res(KIND_DONE, '0, '0, CH_NUL,
                                          CNT_W'({1'b0, n_slot} + 1'b1));
                v_b.cnt = v_b.cnt + 1'b1;
            end
            n_slot  = '0;
            n_pos   = '0;
            n_vpend = 1'b0;
            n_plain = 1'b0;
            n_esc   = ESC_NONE;
            n_seen  = 1'b0;
        end
    end

    assign o_push   = w_acc && (v_b.cnt != '0);
    assign o_bundle = v_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_pos   <= '0;
            r_vpend <= 1'b0;
            r_plain <= 1'b0;
            r_esc   <= ESC_NONE;
            r_seen  <= 1'b0;
        end else if (w_acc) begin
            r_slot  <= n_slot;
            r_pos   <= n_pos;
            r_vpend <= n_vpend;
            r_plain <= n_plain;
            r_esc   <= n_esc;
            r_seen  <= n_seen;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_end) |=> (r_slot == '0 && r_pos == '0 && !r_seen && r_esc == ESC_NONE))
        else $error("state not cleared after end of string");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(SLOT_BYTES - 1))
        else $error("write position beyond slot");

endmodule

`default_nettype wire

/* hw/rtl/qss_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module qss_fifo import qss_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_bundle i_data,
    output      logic    o_full,
    input  wire logic    i_pop,
    output      logic    o_empty,
    output      t_bundle o_data
);

    t_bundle                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr, r_rd;
    logic [FIFO_CNT_W-1:0]  r_cnt;
    logic                   w_wr, w_rd;

    assign o_full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count overflow");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && r_cnt != FIFO_CNT_W'(FIFO_DEPTH)) |-> (r_wr != r_rd))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

/* hw/rtl/qss_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module qss_back import qss_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_head_valid,
    input  wire t_bundle i_head,
    output      logic    o_head_pop,
    output      logic    o_empty,
    input  wire logic    i_pop,
    output      t_out    o_data
);

    logic [RES_IDX_W-1:0] r_idx;
    logic                 w_last;
    logic                 w_take;
    t_res                 w_res;

    assign w_res   = i_head.res[r_idx];
    assign w_last  = (r_idx == i_head.cnt - 1'b1);
    assign w_take  = i_pop && i_head_valid;
    assign o_empty = !i_head_valid;
    assign o_head_pop = w_take && w_last;

    assign o_data.out_kind      = w_res.kind;
    assign o_data.slot_index    = w_res.slot;
    assign o_data.char_position = w_res.pos;
    assign o_data.stored_char   = w_res.ch;
    assign o_data.arg_count     = w_res.cnt;
    assign o_data.last_result   = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_take) begin
            r_idx <= w_last ? '0 : r_idx + 1'b1;
        end
    end

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_idx == '0))
        else $error("result index left over with no request waiting");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (i_head.cnt != '0 && r_idx < i_head.cnt))
        else $error("result index outside request");

endmodule

`default_nettype wire

/* hw/rtl/query_string_splitter_top.sv */
// Splits a query string, one byte per request, into numbered name/value slots and
// emits byte writes (slot, position, byte), a terminator per slot and a final count,
// or an error for an empty string. A byte is accepted every cycle while the internal
// four-entry request queue has room; each request yields zero to four results, which
// leave one per cycle while pop is high; a request holds the output until its last
// result is popped; this sets the sustained rate (one byte per cycle for plain text).
`timescale 1ns / 1ps
`default_nettype none

module query_string_splitter_top import qss_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    input  wire t_in  i_data,
    output      logic full,
    output      logic empty,
    input  wire logic pop,
    output      t_out o_data
);

    logic    w_ready;
    logic    w_push;
    t_bundle w_bundle;
    logic    w_fifo_full;
    logic    w_fifo_empty;
    t_bundle w_head;
    logic    w_head_pop;

    assign full = !w_ready;

    qss_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (push),
        .i_data   (i_data),
        .o_ready  (w_ready),
        .o_push   (w_push),
        .o_bundle (w_bundle),
        .i_full   (w_fifo_full)
    );

    qss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_bundle),
        .o_full  (w_fifo_full),
        .i_pop   (w_head_pop),
        .o_empty (w_fifo_empty),
        .o_data  (w_head)
    );

    qss_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!w_fifo_empty),
        .i_head       (w_head),
        .o_head_pop   (w_head_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_data       (o_data)
    );

endmodule

`default_nettype wire
